// ----- design/gfpp_pkg.sv -----
// Shared types, codes and interlace tables for the GIF frame pixel placer.
`default_nettype none
package gfpp_pkg;

	// Item kinds carried on the action field. Code 3 has no meaning and is dropped.
	typedef enum logic [1:0] {
		ACT_LOAD  = 2'd0,
		ACT_PIXEL = 2'd1,
		ACT_START = 2'd2
	} action_t;

	// Configuration register indexes.
	localparam logic [2:0] CFG_CANVAS_WIDTH  = 3'd0;
	localparam logic [2:0] CFG_FRAME_LEFT    = 3'd1;
	localparam logic [2:0] CFG_BOTTOM_MARGIN = 3'd2;
	localparam logic [2:0] CFG_FRAME_WIDTH   = 3'd3;
	localparam logic [2:0] CFG_FRAME_HEIGHT  = 3'd4;
	localparam logic [2:0] CFG_FRAME_FLAGS   = 3'd5;
	localparam logic [2:0] CFG_TRANSP_INDEX  = 3'd6;
	localparam logic [2:0] CFG_PALETTE_SIZE  = 3'd7;

	// Number of interlace passes; the pass counter parks at this value when done.
	localparam logic [2:0] NUM_PASSES = 3'd4;

	// First row of each interlace pass.
	function automatic logic [2:0] pass_start(input logic [1:0] pass);
		case (pass)
			2'd0:    pass_start = 3'd0;
			2'd1:    pass_start = 3'd4;
			2'd2:    pass_start = 3'd2;
			default: pass_start = 3'd1;
		endcase
	endfunction

	// Row step of each interlace pass.
	function automatic logic [3:0] pass_step(input logic [1:0] pass);
		case (pass)
			2'd0:    pass_step = 4'd8;
			2'd1:    pass_step = 4'd8;
			2'd2:    pass_step = 4'd4;
			default: pass_step = 4'd2;
		endcase
	endfunction

endpackage
`default_nettype wire

// ----- design/gfpp_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none
module gfpp_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ----- design/gif_frame_pixel_placer_unit.sv -----
// Top level of the GIF frame pixel placer: palette store, position tracking and address pipeline.
`default_nettype none
// This block takes the decoded color indices of one GIF frame in stream order
// and turns each into a canvas write: a pixel address (row-major, rows counted
// bottom-up, offset by the frame origin) and the palette color split into red,
// green and blue. Load items fill the palette one entry at a time, start items
// rewind the frame position, and pixel items produce exactly one result each
// until the frame's last pixel, which raises frame_done; further pixels are
// dropped until the next start item. The write is suppressed (write_enable low,
// color zero) for the transparent index when transparency is enabled, or for an
// index at or past the palette size. Rows advance in plain order or through the
// four interlace passes, and passes whose first row lies at or past the frame
// height are skipped. Unless stalled, the block accepts one item every cycle. Two
// register stages sit between input and output: accepting a pixel starts its
// palette RAM read into stage 1, and the output register then loads from stage 1
// behind the row-stride multiply. The input stalls only when stage 1 and the
// output register both hold an item and the receiver stalls. The palette has no
// reset and needs no clearing pass, so items are taken right after reset.
// Configuration registers may be written whenever the block is idle and take
// effect on the next pixel.
module gif_frame_pixel_placer_unit #(
	parameter int PALETTE_ENTRIES = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Item channel.
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire logic [1:0]  action,
	input  wire logic [7:0]  entry_slot,
	input  wire logic [23:0] entry_color,
	input  wire logic [7:0]  pixel_index,
	// Result channel.
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic             write_enable,
	output logic [31:0]      pixel_address,
	output logic [7:0]       red,
	output logic [7:0]       green,
	output logic [7:0]       blue,
	output logic             frame_done,
	// Configuration write channel.
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	import gfpp_pkg::*;

	localparam int AW = $clog2(PALETTE_ENTRIES);

	// Configuration registers.
	logic [15:0] canvas_width_q;
	logic [15:0] frame_left_q;
	logic [15:0] bottom_margin_q;
	logic [15:0] frame_width_q;
	logic [15:0] frame_height_q;
	logic [1:0]  frame_flags_q;
	logic [7:0]  transparent_index_q;
	logic [8:0]  palette_size_q;

	// Frame position state.
	logic [15:0] column_q;
	logic [15:0] row_q;
	logic [2:0]  pass_q;
	logic        finished_q;

	// Stage 1: palette read in flight, address terms captured.
	logic        valid_s1;
	logic        we_s1;
	logic [31:0] line_s1;
	logic [16:0] offs_s1;
	logic        done_s1;

	// Output register.
	logic        result_valid_q;
	logic        write_enable_q;
	logic [31:0] pixel_address_q;
	logic [23:0] color_q;
	logic        frame_done_q;

	// Handshake and decode.
	action_t     act;
	logic        s1_en;
	logic        out_en;
	logic        accept;
	logic        pix_go;
	logic        ram_we;
	logic [23:0] ram_rdata;
	logic        we_c;
	logic [31:0] line_c;
	logic [31:0] prod_c;

	// Position update.
	logic [16:0] col_inc;
	logic [15:0] col_next;
	logic [15:0] row_next;
	logic [2:0]  pass_next;
	logic        fin_next;
	logic [16:0] r_c;
	logic [2:0]  p_c;
	logic        stop_c;

	// The output register frees up when it is empty or its item is taken.
	// Stage 1 moves whenever it is empty or the output register takes it.
	assign out_en     = !result_valid_q || !result_stall;
	assign s1_en      = !valid_s1 || out_en;
	assign item_stall = !s1_en;
	assign accept     = item_valid && !item_stall;
	assign act        = action_t'(action);
	assign cfg_ready  = 1'b1;

	always_comb begin
		ram_we = 1'b0;
		pix_go = 1'b0;
		unique case (act)
			ACT_LOAD: begin
				ram_we = accept && ({1'b0, entry_slot} < 9'(PALETTE_ENTRIES));
			end
			ACT_PIXEL: begin
				pix_go = accept && !finished_q;
			end
			ACT_START: begin
			end
			default: begin
			end
		endcase
	end

	// Palette store. A load and a later read of the same slot never fall in the
	// same cycle, since only one item is accepted per cycle.
	gfpp_ram #(
		.WIDTH (24),
		.DEPTH (PALETTE_ENTRIES)
	) u_palette (
		.clk   (clk),
		.we    (ram_we),
		.waddr (entry_slot[AW-1:0]),
		.wdata (entry_color),
		.re    (pix_go),
		.raddr (pixel_index[AW-1:0]),
		.rdata (ram_rdata)
	);

	// Write enable: not the transparent index, and inside both the configured
	// palette size and the physical store.
	assign we_c = !(frame_flags_q[1] && (pixel_index == transparent_index_q))
		&& ({1'b0, pixel_index} < palette_size_q)
		&& ({1'b0, pixel_index} < 9'(PALETTE_ENTRIES));

	// Canvas row of this pixel, bottom-up, wrapping modulo 2^32.
	assign line_c = 32'(frame_height_q) - 32'(row_q) - 32'd1 + 32'(bottom_margin_q);

	// Next column, row and pass. The interlace search walks at most the four
	// passes, skipping any pass whose start row lies at or past the frame height.
	always_comb begin
		col_next  = column_q;
		row_next  = row_q;
		pass_next = pass_q;
		fin_next  = finished_q;
		col_inc   = {1'b0, column_q} + 17'd1;
		r_c       = {1'b0, row_q} + 17'd1;
		p_c       = pass_q;
		stop_c    = 1'b0;
		if (col_inc >= {1'b0, frame_width_q}) begin
			col_next = '0;
			if (frame_flags_q[0]) begin
				r_c = {1'b0, row_q} + 17'(pass_step(pass_q[1:0]));
				for (int k = 0; k < 4; k++) begin
					if (!stop_c && (r_c >= {1'b0, frame_height_q})) begin
						if (p_c >= NUM_PASSES - 3'd1) begin
							p_c      = NUM_PASSES;
							r_c      = '0;
							fin_next = 1'b1;
							stop_c   = 1'b1;
						end else begin
							p_c = p_c + 3'd1;
							r_c = 17'(pass_start(p_c[1:0]));
						end
					end
				end
				row_next  = r_c[15:0];
				pass_next = p_c;
			end else begin
				if (r_c >= {1'b0, frame_height_q}) begin
					fin_next = 1'b1;
					row_next = '0;
				end else begin
					row_next = r_c[15:0];
				end
			end
		end else begin
			col_next = col_inc[15:0];
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			canvas_width_q      <= 16'd1;
			frame_left_q        <= '0;
			bottom_margin_q     <= '0;
			frame_width_q       <= 16'd1;
			frame_height_q      <= 16'd1;
			frame_flags_q       <= '0;
			transparent_index_q <= '0;
			palette_size_q      <= 9'd256;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_CANVAS_WIDTH:  canvas_width_q      <= cfg_data;
				CFG_FRAME_LEFT:    frame_left_q        <= cfg_data;
				CFG_BOTTOM_MARGIN: bottom_margin_q     <= cfg_data;
				CFG_FRAME_WIDTH:   frame_width_q       <= cfg_data;
				CFG_FRAME_HEIGHT:  frame_height_q      <= cfg_data;
				CFG_FRAME_FLAGS:   frame_flags_q       <= cfg_data[1:0];
				CFG_TRANSP_INDEX:  transparent_index_q <= cfg_data[7:0];
				CFG_PALETTE_SIZE:  palette_size_q      <= cfg_data[8:0];
				default: begin
				end
			endcase
		end
	end

	// Frame position. A start item rewinds it; a live pixel advances it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q   <= '0;
			row_q      <= '0;
			pass_q     <= '0;
			finished_q <= 1'b0;
		end else if (accept && (act == ACT_START)) begin
			column_q   <= '0;
			row_q      <= '0;
			pass_q     <= '0;
			finished_q <= 1'b0;
		end else if (pix_go) begin
			column_q   <= col_next;
			row_q      <= row_next;
			pass_q     <= pass_next;
			finished_q <= fin_next;
		end
	end

	// Stage 1 control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_en) begin
			valid_s1 <= pix_go;
		end
	end

	// Stage 1 payload.
	always_ff @(posedge clk) begin
		if (s1_en && pix_go) begin
			we_s1   <= we_c;
			line_s1 <= line_c;
			offs_s1 <= {1'b0, frame_left_q} + {1'b0, column_q};
			done_s1 <= fin_next;
		end
	end

	// Row stride times canvas row; only the low 32 bits matter.
	assign prod_c = 32'(canvas_width_q) * line_s1;

	// Output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_en) begin
			result_valid_q <= valid_s1;
		end
	end

	// Output register payload. A suppressed write carries a zero color.
	always_ff @(posedge clk) begin
		if (out_en && valid_s1) begin
			write_enable_q  <= we_s1;
			pixel_address_q <= prod_c + 32'(offs_s1);
			color_q         <= we_s1 ? ram_rdata : 24'd0;
			frame_done_q    <= done_s1;
		end
	end

	assign result_valid  = result_valid_q;
	assign write_enable  = write_enable_q;
	assign pixel_address = pixel_address_q;
	assign red           = color_q[23:16];
	assign green         = color_q[15:8];
	assign blue          = color_q[7:0];
	assign frame_done    = frame_done_q;

	// A full stage 1 that cannot move must hold off new items.
	a_stall_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && result_valid_q && result_stall) |-> item_stall)
		else $error("item accepted while stage 1 was blocked");

	// A new result only ever follows a pixel held in stage 1.
	a_result_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(valid_s1))
		else $error("result appeared without a pixel in stage 1");

	// A finished frame always parks its row at zero.
	a_finished_row: assert property (@(posedge clk) disable iff (!arst_n)
		finished_q |-> (row_q == 16'd0))
		else $error("finished frame with nonzero row");

	// The pass counter never runs past its parked value.
	a_pass_range: assert property (@(posedge clk) disable iff (!arst_n)
		pass_q <= NUM_PASSES)
		else $error("interlace pass counter out of range");

endmodule
`default_nettype wire
